// ===== rtl/hsf_pkg.sv =====
// ----------------------------------------------------------------------------
// hsf_pkg: shared types and constants of the homeostatic scaling factor block
// Holds field widths, the fixed-point constants, the square-root table used by
// the exp2 unit and the item and state types.
// ----------------------------------------------------------------------------
package hsf_pkg;

   localparam int RATE_W  = 32;
   localparam int EXP_W   = 16;
   localparam int FAC_W   = 24;
   localparam int FRAC_W  = 24;
   localparam int LOG_W   = 30;
   localparam int PROD_W  = 47;
   localparam int Y_W     = 35;
   localparam int SUM_W   = 32;
   localparam int SQ_W    = 51;
   localparam int CSR_W   = 32;
   localparam int CSR_IDX_W = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_RATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPONENT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_FACTOR  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FACTOR  = 2'd3;

   localparam logic [RATE_W-1:0] RATE_FLOOR = 32'd66;
   localparam logic [FAC_W-1:0]  MASK24     = 24'hFF_FFFF;
   localparam logic [FAC_W-1:0]  ONE_Q16    = 24'h01_0000;

   localparam logic [RATE_W-1:0] TARGET_RESET = 32'd327680;
   localparam logic [EXP_W-1:0]  EXP_RESET    = 16'd4096;
   localparam logic [FAC_W-1:0]  MIN_RESET    = 24'd6554;
   localparam logic [FAC_W-1:0]  MAX_RESET    = 24'd655360;

   localparam logic signed [Y_W-1:0] Y_HI = 35'sd134217728;
   localparam logic signed [Y_W-1:0] Y_LO = -35'sd285212672;

   typedef logic [FRAC_W:0][30:0] root_tab_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] bit_v;
      x = x_in;
      res = '0;
      bit_v = 64'h1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (x >= res + bit_v) begin
            x = x - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   function automatic root_tab_type build_roots();
      root_tab_type r;
      logic [63:0] t;
      r = '0;
      t = isqrt64(64'h1 << 61);
      r[1] = t[30:0];
      for (int k = 1; k < FRAC_W; k++) begin
         t = isqrt64(t << 30);
         r[k+1] = t[30:0];
      end
      return r;
   endfunction

   localparam root_tab_type ROOT_TAB = build_roots();

   typedef enum logic {
      KIND_NORMAL,
      KIND_ZERO_TARGET
   } item_kind_type;

   typedef struct packed {
      logic [RATE_W-1:0] rate;
      logic              last;
      item_kind_type     kind;
   } item_type;

   typedef struct packed {
      logic [RATE_W-1:0]        target_rate;
      logic signed [EXP_W-1:0]  exponent;
      logic [FAC_W-1:0]         min_factor;
      logic [FAC_W-1:0]         max_factor;
   } cfg_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_LOG,
      BK_MUL,
      BK_RANGE,
      BK_EXP_WAIT,
      BK_CLAMP,
      BK_SQUARE,
      BK_ACC,
      BK_MEAN_GO,
      BK_MEAN_WAIT,
      BK_MSQ_WAIT,
      BK_VAR_MUL,
      BK_VAR,
      BK_DONE
   } back_state_type;

endpackage

// ===== rtl/hsf_front.sv =====
// ----------------------------------------------------------------------------
// hsf_front: input side of the scaling factor block
// Accepts rate items, floors the rate, marks the zero-target case and keeps
// them in a short queue for the back end.
// ----------------------------------------------------------------------------
module hsf_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [hsf_pkg::RATE_W-1:0]  req_average_rate,
   input  logic                        req_last_neuron,
   input  logic                        target_zero,
   input  logic                        pop,
   output logic                        item_valid,
   output hsf_pkg::item_type           item
);
   import hsf_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           q_ff [QUEUE_DEPTH];
   item_type           q_in [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   item_type           new_item;
   logic               push;
   logic               pull;

   assign req_stall  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = q_ff[rd_ptr_ff];
   assign push       = req_valid && !req_stall;
   assign pull       = pop && item_valid;

   always_comb begin
      new_item.rate = (req_average_rate < RATE_FLOOR) ? RATE_FLOOR : req_average_rate;
      new_item.last = req_last_neuron;
      new_item.kind = target_zero ? KIND_ZERO_TARGET : KIND_NORMAL;
      q_in = q_ff;
      if (push) begin
         q_in[wr_ptr_ff] = new_item;
      end
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pull ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pull) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pull && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/hsf_log2.sv =====
// ----------------------------------------------------------------------------
// hsf_log2: iterative base-2 logarithm
// Normalizes a nonzero Q16.16 value and squares the mantissa once per cycle to
// produce 24 fraction bits of the signed Q.24 logarithm.
// ----------------------------------------------------------------------------
module hsf_log2 (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [hsf_pkg::RATE_W-1:0]        x,
   output logic                              done,
   output logic signed [hsf_pkg::LOG_W-1:0]  result
);
   import hsf_pkg::*;

   logic [4:0]           p;
   logic [31:0]          m_init;
   logic [63:0]          sq;
   logic [32:0]          t;
   logic [31:0]          m_ff, m_in;
   logic [FRAC_W-1:0]    frac_ff, frac_in;
   logic [4:0]           p_ff, p_in;
   logic [4:0]           step_ff, step_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;

   assign done   = done_ff;
   assign result = $signed({6'({1'b0, p_ff}) - 6'd16, frac_ff});

   always_comb begin
      p = '0;
      for (int i = 0; i < RATE_W; i++) begin
         if (x[i]) begin
            p = 5'(i);
         end
      end
      m_init = x << (5'd31 - p);
      sq     = {32'b0, m_ff} * {32'b0, m_ff};
      t      = sq[63:31];
      m_in    = m_ff;
      frac_in = frac_ff;
      p_in    = p_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         m_in    = m_init;
         frac_in = '0;
         p_in    = p;
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         m_in    = t[32] ? t[32:1] : t[31:0];
         frac_in = {frac_ff[FRAC_W-2:0], t[32]};
         step_in = 5'(step_ff + 1'b1);
         if (step_ff == 5'(FRAC_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      m_ff    <= m_in;
      frac_ff <= frac_in;
      p_ff    <= p_in;
      step_ff <= step_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

endmodule

// ===== rtl/hsf_exp2.sv =====
// ----------------------------------------------------------------------------
// hsf_exp2: iterative base-2 exponential
// Builds 2^f by one table multiply per fraction bit, then scales by 2^n with
// rounding to Q8.16 and saturation at 24 bits.
// ----------------------------------------------------------------------------
module hsf_exp2 (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [5:0]           n,
   input  logic [hsf_pkg::FRAC_W-1:0]  f,
   output logic                        done,
   output logic [hsf_pkg::FAC_W-1:0]   value
);
   import hsf_pkg::*;

   logic [4:0]          idx;
   logic [61:0]         prodm;
   logic [5:0]          shv;
   logic [4:0]          sh;
   logic [31:0]         rnd;
   logic [30:0]         m_ff, m_in;
   logic [FRAC_W-1:0]   f_ff, f_in;
   logic signed [5:0]   n_ff, n_in;
   logic [4:0]          step_ff, step_in;
   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [FAC_W-1:0]    value_ff, value_in;

   assign done  = done_ff;
   assign value = value_ff;

   always_comb begin
      idx   = (step_ff == 5'(FRAC_W)) ? 5'(FRAC_W) : 5'(step_ff + 1'b1);
      prodm = {31'b0, m_ff} * {31'b0, ROOT_TAB[idx]};
      shv   = 6'd14 - n_ff;
      sh    = shv[4:0];
      rnd   = ({1'b0, m_ff} + (32'd1 << (sh - 5'd1))) >> sh;
      m_in     = m_ff;
      f_in     = f_ff;
      n_in     = n_ff;
      step_in  = step_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      value_in = value_ff;
      if (start) begin
         m_in    = 31'h4000_0000;
         f_in    = f;
         n_in    = n;
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (step_ff == 5'(FRAC_W)) begin
            value_in = (rnd > 32'(MASK24)) ? MASK24 : rnd[FAC_W-1:0];
            done_in  = 1'b1;
            run_in   = 1'b0;
         end else begin
            if (f_ff[FRAC_W-1]) begin
               m_in = prodm[60:30];
            end
            f_in    = f_ff << 1;
            step_in = 5'(step_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      m_ff     <= m_in;
      f_ff     <= f_in;
      n_ff     <= n_in;
      step_ff  <= step_in;
      value_ff <= value_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

endmodule

// ===== rtl/hsf_div.sv =====
// ----------------------------------------------------------------------------
// hsf_div: serial restoring divider
// Divides a 51-bit dividend by the neuron count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hsf_div #(
   parameter int DEN_W = 13
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [hsf_pkg::SQ_W-1:0]  dividend,
   input  logic [DEN_W-1:0]          divisor,
   output logic                      done,
   output logic [hsf_pkg::SQ_W-1:0]  quotient
);
   import hsf_pkg::*;

   localparam int STEP_W = $clog2(SQ_W);

   logic [DEN_W:0]      r2;
   logic                ge;
   logic [DEN_W:0]      diff;
   logic [SQ_W-1:0]     num_ff, num_in;
   logic [DEN_W-1:0]    rem_ff, rem_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                run_ff, run_in;
   logic                done_ff, done_in;

   assign done     = done_ff;
   assign quotient = num_ff;

   always_comb begin
      r2      = {rem_ff, num_ff[SQ_W-1]};
      ge      = (r2 >= {1'b0, divisor});
      diff    = r2 - {1'b0, divisor};
      num_in  = num_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         num_in  = {num_ff[SQ_W-2:0], ge};
         rem_in  = ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
         step_in = STEP_W'(step_ff + 1'b1);
         if (step_ff == STEP_W'(SQ_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

endmodule

// ===== rtl/hsf_back.sv =====
// ----------------------------------------------------------------------------
// hsf_back: execution side of the scaling factor block
// Sequences the logarithms, exponent multiply, exp2, clamping, sweep
// statistics and the output register for one queued item at a time.
// ----------------------------------------------------------------------------
module hsf_back #(
   parameter int MAX_NEURONS = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  hsf_pkg::cfg_type            cfg,
   input  logic                        item_valid,
   input  hsf_pkg::item_type           item,
   output logic                        item_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [hsf_pkg::FAC_W-1:0]   rsp_scaling_factor,
   output logic [hsf_pkg::FAC_W-1:0]   rsp_mean_factor,
   output logic [hsf_pkg::FAC_W-1:0]   rsp_factor_variance,
   output logic                        rsp_sweep_end
);
   import hsf_pkg::*;

   localparam int CNT_W = $clog2(MAX_NEURONS + 1);

   back_state_type          state_ff, state_in;
   item_type                cur_ff, cur_in;
   logic [FAC_W-1:0]        raw_ff, raw_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [FAC_W-1:0]        fac_ff, fac_in;
   logic [47:0]             sq_ff, sq_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [SQ_W-1:0]         sqsum_ff, sqsum_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [FAC_W-1:0]        mean_ff, mean_in;
   logic [SQ_W-1:0]         msq_ff, msq_in;
   logic [47:0]             sqm_ff, sqm_in;
   logic [FAC_W-1:0]        var_ff, var_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FAC_W-1:0]        rsp_fac_ff, rsp_fac_in;
   logic [FAC_W-1:0]        rsp_mean_ff, rsp_mean_in;
   logic [FAC_W-1:0]        rsp_var_ff, rsp_var_in;
   logic                    rsp_end_ff, rsp_end_in;

   logic                    log_start;
   logic                    lt_done, lr_done;
   logic signed [LOG_W-1:0] lt, lr;
   logic signed [LOG_W:0]   d;
   logic signed [Y_W-1:0]   y;
   logic                    y_high, y_low;
   logic                    exp_start, exp_done;
   logic [FAC_W-1:0]        exp_value;
   logic                    div_start, div_done;
   logic [SQ_W-1:0]         div_num, div_q;
   logic                    slot_free;
   logic [FAC_W-1:0]        lo_clamped;
   logic [SUM_W:0]          sum_wide;
   logic [SQ_W:0]           sqsum_wide;
   logic [SQ_W:0]           var_wide;
   logic [SUM_W:0]          mean_num;

   assign d         = LOG_W'(lt) - LOG_W'(lr);
   assign y         = $signed(prod_ff[PROD_W-1:12]);
   assign y_high    = (y >= Y_HI);
   assign y_low     = (y < Y_LO);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign mean_num  = {1'b0, sum_ff} + (SUM_W+1)'(count_ff >> 1);

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_scaling_factor  = rsp_fac_ff;
   assign rsp_mean_factor     = rsp_mean_ff;
   assign rsp_factor_variance = rsp_var_ff;
   assign rsp_sweep_end       = rsp_end_ff;

   hsf_log2 u_log_target (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .x      (cfg.target_rate),
      .done   (lt_done),
      .result (lt)
   );

   hsf_log2 u_log_rate (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .x      (cur_in.rate),
      .done   (lr_done),
      .result (lr)
   );

   hsf_exp2 u_exp2 (
      .clock (clock),
      .reset (reset),
      .start (exp_start),
      .n     (y[29:24]),
      .f     (y[FRAC_W-1:0]),
      .done  (exp_done),
      .value (exp_value)
   );

   hsf_div #(
      .DEN_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (item_valid) begin
               state_in = (item.kind == KIND_ZERO_TARGET) ? BK_CLAMP : BK_LOG;
            end
         end
         BK_LOG: begin
            if (lt_done && lr_done) begin
               state_in = BK_MUL;
            end
         end
         BK_MUL:   state_in = BK_RANGE;
         BK_RANGE: state_in = (y_high || y_low) ? BK_CLAMP : BK_EXP_WAIT;
         BK_EXP_WAIT: begin
            if (exp_done) begin
               state_in = BK_CLAMP;
            end
         end
         BK_CLAMP:   state_in = BK_SQUARE;
         BK_SQUARE:  state_in = BK_ACC;
         BK_ACC:     state_in = cur_ff.last ? BK_MEAN_GO : BK_DONE;
         BK_MEAN_GO: state_in = BK_MEAN_WAIT;
         BK_MEAN_WAIT: begin
            if (div_done) begin
               state_in = BK_MSQ_WAIT;
            end
         end
         BK_MSQ_WAIT: begin
            if (div_done) begin
               state_in = BK_VAR_MUL;
            end
         end
         BK_VAR_MUL: state_in = BK_VAR;
         BK_VAR:     state_in = BK_DONE;
         BK_DONE: begin
            if (slot_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      item_pop  = (state_ff == BK_IDLE) && item_valid;
      log_start = item_pop && (item.kind == KIND_NORMAL);
      exp_start = (state_ff == BK_RANGE) && !y_high && !y_low;
      div_start = (state_ff == BK_MEAN_GO) || ((state_ff == BK_MEAN_WAIT) && div_done);
      div_num   = (state_ff == BK_MEAN_GO) ? SQ_W'(mean_num) : sqsum_ff;
   end

   always_comb begin
      cur_in   = item_pop ? item : cur_ff;
      raw_in   = raw_ff;
      prod_in  = prod_ff;
      fac_in   = fac_ff;
      sq_in    = sq_ff;
      sum_in   = sum_ff;
      sqsum_in = sqsum_ff;
      count_in = count_ff;
      mean_in  = mean_ff;
      msq_in   = msq_ff;
      sqm_in   = sqm_ff;
      var_in   = var_ff;
      rsp_fac_in  = rsp_fac_ff;
      rsp_mean_in = rsp_mean_ff;
      rsp_var_in  = rsp_var_ff;
      rsp_end_in  = rsp_end_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      lo_clamped = (raw_ff < cfg.min_factor) ? cfg.min_factor : raw_ff;
      sum_wide   = {1'b0, sum_ff} + (SUM_W+1)'(fac_ff);
      sqsum_wide = {1'b0, sqsum_ff} + (SQ_W+1)'(sq_ff);
      var_wide   = {1'b0, msq_ff} - (SQ_W+1)'(sqm_ff) + (SQ_W+1)'(32768);
      case (state_ff)
         BK_IDLE: begin
            if (item_pop && item.kind == KIND_ZERO_TARGET) begin
               if (cfg.exponent > 0) begin
                  raw_in = '0;
               end else if (cfg.exponent == 0) begin
                  raw_in = ONE_Q16;
               end else begin
                  raw_in = MASK24;
               end
            end
         end
         BK_MUL: prod_in = d * cfg.exponent;
         BK_RANGE: begin
            if (y_high) begin
               raw_in = MASK24;
            end else if (y_low) begin
               raw_in = '0;
            end
         end
         BK_EXP_WAIT: begin
            if (exp_done) begin
               raw_in = exp_value;
            end
         end
         BK_CLAMP: begin
            fac_in = (lo_clamped > cfg.max_factor) ? cfg.max_factor : lo_clamped;
         end
         BK_SQUARE: sq_in = {24'b0, fac_ff} * {24'b0, fac_ff};
         BK_ACC: begin
            sum_in   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
            sqsum_in = sqsum_wide[SQ_W] ? '1 : sqsum_wide[SQ_W-1:0];
            if (count_ff < CNT_W'(MAX_NEURONS)) begin
               count_in = CNT_W'(count_ff + 1'b1);
            end
         end
         BK_MEAN_WAIT: begin
            if (div_done) begin
               mean_in = (div_q > SQ_W'(MASK24)) ? MASK24 : div_q[FAC_W-1:0];
            end
         end
         BK_MSQ_WAIT: begin
            if (div_done) begin
               msq_in = div_q;
            end
         end
         BK_VAR_MUL: sqm_in = {24'b0, mean_ff} * {24'b0, mean_ff};
         BK_VAR: begin
            if (msq_ff > SQ_W'(sqm_ff)) begin
               var_in = (var_wide[SQ_W:16] > (SQ_W-15)'(MASK24)) ? MASK24
                        : var_wide[FAC_W+15:16];
            end else begin
               var_in = '0;
            end
         end
         BK_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_fac_in   = fac_ff;
               rsp_mean_in  = cur_ff.last ? mean_ff : '0;
               rsp_var_in   = cur_ff.last ? var_ff : '0;
               rsp_end_in   = cur_ff.last;
               if (cur_ff.last) begin
                  sum_in   = '0;
                  sqsum_in = '0;
                  count_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      raw_ff      <= raw_in;
      prod_ff     <= prod_in;
      fac_ff      <= fac_in;
      sq_ff       <= sq_in;
      mean_ff     <= mean_in;
      msq_ff      <= msq_in;
      sqm_ff      <= sqm_in;
      var_ff      <= var_in;
      rsp_fac_ff  <= rsp_fac_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_var_ff  <= rsp_var_in;
      rsp_end_ff  <= rsp_end_in;
      if (reset) begin
         state_ff     <= BK_IDLE;
         sum_ff       <= '0;
         sqsum_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         sqsum_ff     <= sqsum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/homeostatic_scaling_factor.sv =====
// ----------------------------------------------------------------------------
// homeostatic_scaling_factor: homeostatic synaptic scaling factor unit
// Each req transfer carries one neuron's average rate (Q16.16) and a last flag.
// The unit returns one rsp transfer with factor = (target/rate)^exponent in
// Q8.16, clamped to min_factor and then max_factor. On the last neuron of a
// sweep the rsp also carries the mean and variance of the sweep's factors and
// sweep_end; the running sums then clear.
// The csr port writes target_rate, the exponent, min_factor, max_factor by
// index; write only while the unit is idle.
// An ordinary item goes from req transfer to rsp_valid through the two
// 24-step log2 units, which run side by side, then the exponent multiply and
// the 25-step exp2 unit. A factor outside the exp2 range skips the exp2 unit,
// and a zero target skips all three. A last item adds two 51-step serial
// divisions by the neuron count. The back end works on one item at a time; a
// two-entry queue takes further items meanwhile.
// A held rsp keeps the back end from passing its next result to the output
// register, but the queue still takes transfers until it is full.
// Reset restores the default register values, clears the queue, the sweep
// sums and the output valid flag.
// ----------------------------------------------------------------------------
module homeostatic_scaling_factor #(
   parameter int MAX_NEURONS = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [hsf_pkg::RATE_W-1:0]      req_average_rate,
   input  logic                            req_last_neuron,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [hsf_pkg::FAC_W-1:0]       rsp_scaling_factor,
   output logic [hsf_pkg::FAC_W-1:0]       rsp_mean_factor,
   output logic [hsf_pkg::FAC_W-1:0]       rsp_factor_variance,
   output logic                            rsp_sweep_end,
   input  logic                            csr_wr_en,
   input  logic [hsf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hsf_pkg::CSR_W-1:0]       csr_wdata
);
   import hsf_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       item_valid;
   item_type   item;
   logic       item_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_TARGET_RATE: cfg_in.target_rate = csr_wdata;
            CSR_EXPONENT:    cfg_in.exponent    = $signed(csr_wdata[EXP_W-1:0]);
            CSR_MIN_FACTOR:  cfg_in.min_factor  = csr_wdata[FAC_W-1:0];
            CSR_MAX_FACTOR:  cfg_in.max_factor  = csr_wdata[FAC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_rate <= TARGET_RESET;
         cfg_ff.exponent    <= $signed(EXP_RESET);
         cfg_ff.min_factor  <= MIN_RESET;
         cfg_ff.max_factor  <= MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hsf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_average_rate (req_average_rate),
      .req_last_neuron  (req_last_neuron),
      .target_zero      (cfg_ff.target_rate == '0),
      .pop              (item_pop),
      .item_valid       (item_valid),
      .item             (item)
   );

   hsf_back #(
      .MAX_NEURONS (MAX_NEURONS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .item_valid          (item_valid),
      .item                (item),
      .item_pop            (item_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_scaling_factor  (rsp_scaling_factor),
      .rsp_mean_factor     (rsp_mean_factor),
      .rsp_factor_variance (rsp_factor_variance),
      .rsp_sweep_end       (rsp_sweep_end)
   );

endmodule

// ===== tb/hsf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsf_checker: result checker for the homeostatic scaling factor unit
// Watches the configuration port and both channels. Every req transfer is run
// through a local fixed-point model of the factor and sweep statistics, and
// every rsp transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module hsf_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [hsf_pkg::RATE_W-1:0]    req_average_rate,
   input  logic                          req_last_neuron,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [hsf_pkg::FAC_W-1:0]     rsp_scaling_factor,
   input  logic [hsf_pkg::FAC_W-1:0]     rsp_mean_factor,
   input  logic [hsf_pkg::FAC_W-1:0]     rsp_factor_variance,
   input  logic                          rsp_sweep_end,
   input  logic                          csr_wr_en,
   input  logic [hsf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hsf_pkg::CSR_W-1:0]     csr_wdata,
   output int                            mismatches,
   output int                            outstanding
);
   import hsf_pkg::*;

   localparam int NEURON_CAP = 4096;
   localparam longint ONE_Q24 = 64'sd16777216;

   typedef struct packed {
      logic [FAC_W-1:0] factor;
      logic [FAC_W-1:0] mean;
      logic [FAC_W-1:0] variance;
      logic             sweep_end;
   } factor_result_type;

   factor_result_type factor_queue[$];
   logic [63:0] exp2_roots[1:24];
   logic [RATE_W-1:0] target_q;
   logic signed [EXP_W-1:0] exponent_q;
   logic [FAC_W-1:0] min_q;
   logic [FAC_W-1:0] max_q;
   logic [63:0] sum_acc;
   logic [63:0] square_acc;
   int neuron_total;

   function automatic logic [63:0] int_sqrt(input logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] bit_v;
      x = x_in;
      res = '0;
      bit_v = 64'h1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (x >= res + bit_v) begin
            x = x - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   function automatic longint log2_q24(input logic [31:0] x);
      int p;
      logic [63:0] m;
      longint frac;
      p = 31;
      while (p > 0 && !x[p]) p--;
      m = 64'(x) << (31 - p);
      frac = 0;
      for (int i = 0; i < 24; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            frac = frac | 1;
            m = m >> 1;
         end
      end
      return longint'(p - 16) * ONE_Q24 + frac;
   endfunction

   function automatic logic [FAC_W-1:0] exp2_q16(input longint y);
      longint yo;
      int n;
      int sh;
      logic [63:0] f;
      logic [63:0] m;
      if (y >= 8 * ONE_Q24) return MASK24;
      if (y < -17 * ONE_Q24) return '0;
      yo = y + 32 * ONE_Q24;
      n = int'(yo >>> 24) - 32;
      f = 64'(yo) & 64'hFF_FFFF;
      m = 64'h1 << 30;
      for (int k = 1; k <= 24; k++) begin
         if (f[24-k]) m = (m * exp2_roots[k]) >> 30;
      end
      sh = 14 - n;
      m = (m + (64'h1 << (sh - 1))) >> sh;
      return (m > 64'hFF_FFFF) ? MASK24 : m[FAC_W-1:0];
   endfunction

   function automatic logic [FAC_W-1:0] unclamped_factor(input logic [31:0] rate_in);
      logic [31:0] rate;
      longint d;
      longint prod;
      rate = (rate_in < RATE_FLOOR) ? RATE_FLOOR : rate_in;
      if (target_q == 0) begin
         if (exponent_q > 0) return '0;
         if (exponent_q == 0) return ONE_Q16;
         return MASK24;
      end
      d = log2_q24(target_q) - log2_q24(rate);
      prod = d * longint'(exponent_q);
      return exp2_q16(prod >>> 12);
   endfunction

   function automatic factor_result_type predict_neuron(input logic [31:0] rate,
                                                        input logic last);
      factor_result_type r;
      logic [63:0] fac;
      logic [63:0] mean;
      logic [63:0] msq;
      logic [63:0] sqm;
      logic [63:0] var_v;
      fac = 64'(unclamped_factor(rate));
      if (fac < 64'(min_q)) fac = 64'(min_q);
      if (fac > 64'(max_q)) fac = 64'(max_q);
      sum_acc = sum_acc + fac;
      if (sum_acc > 64'hFFFF_FFFF) sum_acc = 64'hFFFF_FFFF;
      square_acc = square_acc + fac * fac;
      if (square_acc > (64'h1 << 51) - 1) square_acc = (64'h1 << 51) - 1;
      neuron_total = (neuron_total + 1 > NEURON_CAP) ? NEURON_CAP : neuron_total + 1;
      mean = 0;
      var_v = 0;
      if (last) begin
         mean = (sum_acc + 64'(neuron_total / 2)) / 64'(neuron_total);
         if (mean > 64'hFF_FFFF) mean = 64'hFF_FFFF;
         msq = square_acc / 64'(neuron_total);
         sqm = mean * mean;
         if (msq > sqm) begin
            var_v = (msq - sqm + 64'd32768) >> 16;
            if (var_v > 64'hFF_FFFF) var_v = 64'hFF_FFFF;
         end
         sum_acc = 0;
         square_acc = 0;
         neuron_total = 0;
      end
      r.factor = fac[FAC_W-1:0];
      r.mean = mean[FAC_W-1:0];
      r.variance = var_v[FAC_W-1:0];
      r.sweep_end = last;
      return r;
   endfunction

   initial begin
      logic [63:0] t;
      t = int_sqrt(64'h1 << 61);
      exp2_roots[1] = t;
      for (int k = 1; k < 24; k++) begin
         t = int_sqrt(t << 30);
         exp2_roots[k+1] = t;
      end
      mismatches = 0;
   end

   assign outstanding = factor_queue.size();

   always @(posedge clock) begin
      factor_result_type want;
      if (reset) begin
         target_q <= TARGET_RESET;
         exponent_q <= EXP_RESET;
         min_q <= MIN_RESET;
         max_q <= MAX_RESET;
         sum_acc = 0;
         square_acc = 0;
         neuron_total = 0;
         factor_queue.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_TARGET_RATE: target_q <= csr_wdata;
               CSR_EXPONENT: exponent_q <= csr_wdata[EXP_W-1:0];
               CSR_MIN_FACTOR: min_q <= csr_wdata[FAC_W-1:0];
               CSR_MAX_FACTOR: max_q <= csr_wdata[FAC_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (factor_queue.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("%0t: unexpected rsp transfer factor=%h", $time,
                           rsp_scaling_factor);
            end else begin
               want = factor_queue.pop_front();
               if (rsp_scaling_factor !== want.factor || rsp_mean_factor !== want.mean ||
                   rsp_factor_variance !== want.variance ||
                   rsp_sweep_end !== want.sweep_end) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("%0t: rsp mismatch exp f=%h m=%h v=%h e=%b got f=%h m=%h v=%h e=%b",
                              $time, want.factor, want.mean, want.variance, want.sweep_end,
                              rsp_scaling_factor, rsp_mean_factor, rsp_factor_variance,
                              rsp_sweep_end);
               end
            end
         end
         if (req_valid && !req_stall)
            factor_queue.push_back(predict_neuron(req_average_rate, req_last_neuron));
      end
   end

endmodule

// ===== tb/homeostatic_scaling_factor_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homeostatic_scaling_factor_tb: testbench top of the scaling factor unit
// Drives directed and random neuron rates and sweep boundaries through a
// series of register settings, with random gaps and back-pressure, and
// reports the verdict of the attached checker.
// ----------------------------------------------------------------------------
module homeostatic_scaling_factor_tb;
   import hsf_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [RATE_W-1:0] req_average_rate;
   logic req_last_neuron;
   logic rsp_valid;
   logic rsp_stall;
   logic [FAC_W-1:0] rsp_scaling_factor;
   logic [FAC_W-1:0] rsp_mean_factor;
   logic [FAC_W-1:0] rsp_factor_variance;
   logic rsp_sweep_end;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;
   int mismatches;
   int outstanding;
   int idle_cycles;
   bit smooth_flow;
   logic [RATE_W-1:0] rate_center;

   homeostatic_scaling_factor dut (.*);

   hsf_checker checker_i (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (smooth_flow || r < 65) return 0;
      if (r < 94) return $urandom_range(3, 1);
      return $urandom_range(60, 10);
   endfunction

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int hold;
      rsp_stall = 1'b0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall = 1'b1;
            hold--;
         end else begin
            rsp_stall = 1'b0;
            hold = pick_gap();
         end
      end
   end

   task automatic send_neuron(input logic [RATE_W-1:0] rate, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_average_rate = rate;
      req_last_neuron = last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (250) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic load_settings(input logic [31:0] target, input logic [15:0] expo,
                                input logic [23:0] lo, input logic [23:0] hi);
      settle();
      write_csr(CSR_TARGET_RATE, target);
      write_csr(CSR_EXPONENT, {16'h0, expo});
      write_csr(CSR_MIN_FACTOR, {8'h0, lo});
      write_csr(CSR_MAX_FACTOR, {8'h0, hi});
      rate_center = target;
   endtask

   function automatic logic [RATE_W-1:0] random_rate();
      int r;
      logic [RATE_W-1:0] delta;
      r = $urandom_range(99);
      delta = $urandom_range(65535);
      if (r < 35) return $urandom;
      if (r < 70) return (rate_center >> $urandom_range(3)) + delta;
      if (r < 85) return $urandom_range(200);
      return $urandom >> $urandom_range(31);
   endfunction

   task automatic run_sweeps(input int count);
      for (int i = 0; i < count; i++)
         send_neuron(random_rate(), ($urandom_range(15) == 0) || i == count - 1);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_average_rate = '0;
      req_last_neuron = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_TARGET_RATE;
      csr_wdata = '0;
      smooth_flow = 1'b0;
      rate_center = TARGET_RESET;
      repeat (9) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      send_neuron(32'd0, 1'b0);
      send_neuron(32'd1, 1'b0);
      send_neuron(32'd65, 1'b0);
      send_neuron(32'd66, 1'b0);
      send_neuron(32'd67, 1'b0);
      send_neuron(32'hFFFF_FFFF, 1'b0);
      send_neuron(TARGET_RESET, 1'b0);
      send_neuron(32'h8000_0000, 1'b0);
      send_neuron(32'h0001_0000, 1'b1);
      send_neuron(32'd12345, 1'b1);
      load_settings(32'd0, 16'h1000, 24'd0, 24'hFF_FFFF);
      send_neuron(32'd100, 1'b0);
      send_neuron(32'hFFFF_FFFF, 1'b1);
      load_settings(32'd0, 16'h0000, 24'd0, 24'hFF_FFFF);
      send_neuron(32'd100, 1'b1);
      load_settings(32'd0, 16'h8000, 24'd0, 24'hFF_FFFF);
      send_neuron(32'd100, 1'b1);
      load_settings(32'hFFFF_FFFF, 16'h7FFF, 24'd0, 24'hFF_FFFF);
      send_neuron(32'd0, 1'b0);
      send_neuron(32'hFFFF_FFFF, 1'b1);
      load_settings(32'd1, 16'h8000, 24'd0, 24'hFF_FFFF);
      send_neuron(32'hFFFF_FFFF, 1'b0);
      send_neuron(32'd0, 1'b1);
      load_settings(32'd327680, 16'h1000, 24'd700000, 24'd600000);
      send_neuron(32'd1000, 1'b1);

      // Saturate both sweep accumulators with full-scale factors.
      load_settings(32'hFFFF_FFFF, 16'h7FFF, 24'hFF_FFFF, 24'hFF_FFFF);
      smooth_flow = 1'b1;
      for (int i = 0; i < 300; i++) send_neuron($urandom, i == 299);
      smooth_flow = 1'b0;

      for (int phase = 0; phase < 8; phase++) begin
         load_settings($urandom >> $urandom_range(16), 16'($urandom),
                       24'($urandom_range(70000)), 24'hFF_FFFF >> $urandom_range(12));
         smooth_flow = (phase == 3);
         run_sweeps(150);
      end
      smooth_flow = 1'b0;
      load_settings(TARGET_RESET, EXP_RESET, MIN_RESET, MAX_RESET);
      run_sweeps(40);

      settle();
      if (mismatches == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
